FILE: design/cte_pkg.sv
// shared types, constants and tables for the civil time to epoch seconds pipeline
`timescale 1ns / 1ps

package cte_pkg;

  // calendar constants
  localparam int YearBias     = 1900;
  localparam int DaysPerEra   = 146097;
  localparam int EpochShift   = 719468;
  localparam int YearsPerEra  = 400;
  localparam int DaysPerYear  = 365;
  localparam int SecsPerDay   = 86400;

  // field widths
  localparam int YearW   = 14;
  localparam int MonthW  = 8;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int ResultW = 39;

  // packed stream widths, padded to whole bytes
  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  // march-based year, day of year and time of day
  typedef struct packed {
    logic signed [14:0] year_mar;
    logic signed [9:0]  doy;
    logic [16:0]        hms;
  } fold_t;

  // day count split into era part and day of era
  typedef struct packed {
    logic signed [23:0] era_days;
    logic signed [18:0] doe;
    logic [16:0]        hms;
  } parts_t;

  // day of a march-based year at which each month starts, indexed by month 0 = january
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] res;
    res = 9'd0;
    case (mon)
      4'd0:    res = 9'd306;
      4'd1:    res = 9'd337;
      4'd2:    res = 9'd0;
      4'd3:    res = 9'd31;
      4'd4:    res = 9'd61;
      4'd5:    res = 9'd92;
      4'd6:    res = 9'd122;
      4'd7:    res = 9'd153;
      4'd8:    res = 9'd184;
      4'd9:    res = 9'd214;
      4'd10:   res = 9'd245;
      4'd11:   res = 9'd275;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/cte_fold.sv
// first stage: month fold into year, march shift, day of year, time of day in seconds
`timescale 1ns / 1ps

module cte_fold (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [13:0]          year_since_1900,
  input  logic signed [7:0]           month_index,
  input  logic [4:0]                  day_of_month,
  input  logic [4:0]                  hour_of_day,
  input  logic [5:0]                  minute_of_hour,
  input  logic [5:0]                  second_of_minute,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cte_pkg::fold_t              out_data
);
  import cte_pkg::*;

  logic               adv;
  logic [8:0]         mon_ofs;
  logic [15:0]        q_prod;
  logic [4:0]         q;
  logic [3:0]         rem;
  logic signed [14:0] year_full;
  fold_t              data_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // floor(month / 12) by reciprocal on month + 132, which is never negative
  always_comb begin
    mon_ofs   = {month_index[7], month_index} + 9'd132;
    q_prod    = 16'(mon_ofs) * 16'd171;
    q         = q_prod[15:11];
    rem       = 4'(mon_ofs - 9'(9'(q) * 9'd12));
    year_full = 15'(year_since_1900) + 15'(YearBias);
    data_next.year_mar = year_full + $signed({1'b0, q}) - 15'sd11
                         - ((rem <= 4'd1) ? 15'sd1 : 15'sd0);
    data_next.doy = $signed({1'b0, month_start(rem)}) + $signed({5'b0, day_of_month})
                    - 10'sd1;
    data_next.hms = 17'(hour_of_day) * 17'd3600 + 17'(minute_of_hour) * 17'd60
                    + 17'(second_of_minute);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: design/cte_era.sv
// two stages: 400-year era split, then day of era and era day offset
`timescale 1ns / 1ps

module cte_era (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cte_pkg::fold_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cte_pkg::parts_t out_data
);
  import cte_pkg::*;

  // stage a registers
  logic               a_valid;
  logic signed [6:0]  a_era;
  logic [8:0]         a_yoe;
  logic signed [9:0]  a_doy;
  logic [16:0]        a_hms;

  logic               a_adv;
  logic               b_adv;
  logic [14:0]        y_ofs;
  logic [27:0]        q_prod;
  logic [5:0]         q;
  logic signed [6:0]  era_next;
  logic [8:0]         yoe_next;
  logic [13:0]        c_prod;
  logic [18:0]        doe_base;
  parts_t             b_next;

  assign b_adv    = !out_valid || out_ready;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  // floor(year / 400) on year + 6400, which is never negative
  always_comb begin
    y_ofs    = 15'(in_data.year_mar + 15'sd6400);
    q_prod   = 28'(y_ofs) * 28'd10486;
    q        = q_prod[27:22];
    era_next = $signed({1'b0, q}) - 7'sd16;
    yoe_next = 9'(y_ofs - 15'(15'(q) * 15'(YearsPerEra)));
  end

  // day of era and start day of the era
  always_comb begin
    c_prod   = 14'(a_yoe) * 14'd41;
    doe_base = 19'(a_yoe) * 19'(DaysPerYear) + 19'(a_yoe[8:2]) - 19'(c_prod[13:12]);
    b_next.doe      = $signed(doe_base) + 19'(a_doy);
    b_next.era_days = 24'(a_era) * 24'(DaysPerEra);
    b_next.hms      = a_hms;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= in_valid;
      end
      if (b_adv) begin
        out_valid <= a_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_era <= era_next;
      a_yoe <= yoe_next;
      a_doy <= in_data.doy;
      a_hms <= in_data.hms;
    end
    if (b_adv && a_valid) begin
      out_data <= b_next;
    end
  end

endmodule

FILE: design/cte_scale.sv
// three stages: day count from epoch, scale to seconds, add time of day
`timescale 1ns / 1ps

module cte_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cte_pkg::parts_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [38:0]     result
);
  import cte_pkg::*;

  logic               c_valid;
  logic signed [24:0] c_days;
  logic [16:0]        c_hms;
  logic               d_valid;
  logic signed [41:0] d_prod;
  logic [16:0]        d_hms;

  logic               c_adv;
  logic               d_adv;
  logic               e_adv;
  logic signed [41:0] total;

  assign e_adv    = !out_valid || out_ready;
  assign d_adv    = !d_valid || e_adv;
  assign c_adv    = !c_valid || d_adv;
  assign in_ready = c_adv;

  assign total = d_prod + $signed({25'b0, d_hms});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_adv) begin
        c_valid <= in_valid;
      end
      if (d_adv) begin
        d_valid <= c_valid;
      end
      if (e_adv) begin
        out_valid <= d_valid;
      end
    end
  end

  // payload: days, product, sum
  always_ff @(posedge clk) begin
    if (c_adv && in_valid) begin
      c_days <= 25'(in_data.era_days) + 25'(in_data.doe) - 25'(EpochShift);
      c_hms  <= in_data.hms;
    end
    if (d_adv && c_valid) begin
      d_prod <= 42'(c_days) * 42'(SecsPerDay);
      d_hms  <= c_hms;
    end
    if (e_adv && d_valid) begin
      result <= total[38:0];
    end
  end

endmodule

FILE: design/civil_time_to_epoch_seconds.sv
// top level: broken-down utc time to signed seconds since 1970-01-01
//
//   channel   dir  beat contents
//   s_axis    in   s_tdata: year, month, day, hour, minute, second
//   m_axis    out  m_tdata: epoch seconds, 39-bit two's complement
//
// one beat in, one beat out; a new beat can be taken every cycle while m_tready does not stall the output
// the stages in order: fold, era split, day of era, day count, multiply, add
// the days times 86400 multiply sets the stage depth
// rst clears all valid bits; payload registers are not reset
// a stall on m_tready holds the output and back-fills empty stages first
`timescale 1ns / 1ps

module civil_time_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [13:0] year_since_1900, [21:14] month_index, [26:22] day_of_month,
  // [31:27] hour_of_day, [37:32] minute_of_hour, [43:38] second_of_minute, [47:44] zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [38:0] epoch_seconds, [39] zero
  output logic [39:0] m_tdata
);
  import cte_pkg::*;

  logic        fold_valid;
  logic        fold_ready;
  fold_t       fold_data;
  logic        era_valid;
  logic        era_ready;
  parts_t      era_data;
  logic [38:0] epoch_seconds;

  // month fold and time of day
  cte_fold u_fold (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .year_since_1900  ($signed(s_tdata[13:0])),
    .month_index      ($signed(s_tdata[21:14])),
    .day_of_month     (s_tdata[26:22]),
    .hour_of_day      (s_tdata[31:27]),
    .minute_of_hour   (s_tdata[37:32]),
    .second_of_minute (s_tdata[43:38]),
    .out_valid        (fold_valid),
    .out_ready        (fold_ready),
    .out_data         (fold_data)
  );

  // era split and day of era
  cte_era u_era (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fold_valid),
    .in_ready  (fold_ready),
    .in_data   (fold_data),
    .out_valid (era_valid),
    .out_ready (era_ready),
    .out_data  (era_data)
  );

  // day count and scaling to seconds
  cte_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (era_valid),
    .in_ready  (era_ready),
    .in_data   (era_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (epoch_seconds)
  );

  assign m_tdata = {1'b0, epoch_seconds};

endmodule

FILE: design/cte_checker.sv
// port-level checks for the epoch seconds pipeline, bound to the top level
`timescale 1ns / 1ps

module cte_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a stalled output beat stays and holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat dropped or changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // with the sink ready every stage moves, so the input is open
  a_ready_flow: assert property (@(posedge clk)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // padding bit above the result is zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[39])
    else $error("output padding bit set");

endmodule

bind civil_time_to_epoch_seconds cte_checker u_cte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
